// ----- sv/lfsc_pkg.sv -----
// Shared types, constants and the microcode program for the line-follow controller.
package lfsc_pkg;

  // Step counter width.
  localparam int PC_BITS = 3;

  // Datapath operations selected by a control word.
  typedef enum logic [2:0] {
    OP_SQ     = 3'd0,
    OP_SCALE  = 3'd1,
    OP_RECIP  = 3'd2,
    OP_STEER  = 3'd3,
    OP_COMMIT = 3'd4
  } op_t;

  // One control word of the program.
  typedef struct packed {
    op_t                op;
    logic               skip_jump;
    logic [PC_BITS-1:0] target;
    logic               last;
  } ucode_t;

  // Sequencer to datapath control bundle.
  typedef struct packed {
    logic   run;
    ucode_t uc;
  } seq_ctl_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MODE_FAST     = 3'd0,
    REG_MODE_SHARP    = 3'd1,
    REG_ADAPTIVE_GAIN = 3'd2,
    REG_LINE_CENTER   = 3'd3,
    REG_SERVO_CENTER  = 3'd4,
    REG_SERVO_LOW     = 3'd5,
    REG_SERVO_HIGH    = 3'd6
  } cfg_reg_t;

  // Program step addresses.
  localparam logic [PC_BITS-1:0] STEP_SQ     = 3'd0;
  localparam logic [PC_BITS-1:0] STEP_SCALE  = 3'd1;
  localparam logic [PC_BITS-1:0] STEP_RECIP  = 3'd2;
  localparam logic [PC_BITS-1:0] STEP_STEER  = 3'd3;
  localparam logic [PC_BITS-1:0] STEP_COMMIT = 3'd4;

  // Division by 20 is a shift by two, then a multiply by ceil(2^23 / 5).
  localparam logic [20:0] RECIP_MUL   = 21'd1677722;
  localparam int          RECIP_SHIFT = 23;

  // Speed profiles.
  localparam logic [8:0] BASE_DEFAULT  = 9'd185;
  localparam logic [8:0] FLOOR_DEFAULT = 9'd150;
  localparam logic [8:0] BASE_FAST     = 9'd260;
  localparam logic [8:0] FLOOR_FAST    = 9'd190;
  localparam logic [8:0] FLOOR_SHARP   = 9'd210;
  localparam logic [8:0] SPEED_BOTH    = 9'd170;
  localparam logic [8:0] SPEED_BOOST   = 9'd300;
  localparam logic [8:0] PWM_TOP       = 9'd500;

  // Slowdown factors in twentieths.
  localparam logic [5:0] FACTOR_20 = 6'd20;
  localparam logic [5:0] FACTOR_30 = 6'd30;
  localparam logic [5:0] FACTOR_8  = 6'd8;
  localparam logic [5:0] FACTOR_17 = 6'd17;
  localparam logic [5:0] FACTOR_36 = 6'd36;

  // Timers and thresholds.
  localparam logic [7:0] BOOST_LIMIT    = 8'd120;
  localparam logic [8:0] START_LIMIT    = 9'd400;
  localparam logic [5:0] FINISH_LIMIT   = 6'd40;
  localparam logic [5:0] FINISH_SAT     = 6'd41;
  localparam logic [7:0] LOST_LIMIT     = 8'd50;

  // Steering gains.
  localparam logic [4:0] GAIN_RESET = 5'd25;
  localparam logic [4:0] GAIN_HIGH  = 5'd30;
  localparam logic [4:0] GAIN_LOW   = 5'd5;

  // The control program: square, scale, divide, steer, commit.
  // The first step jumps past the speed arithmetic when the speed is overridden.
  function automatic ucode_t ucode_rom(input logic [PC_BITS-1:0] pc);
    ucode_t w;
    w = '{op: OP_COMMIT, skip_jump: 1'b0, target: STEP_COMMIT, last: 1'b1};
    unique case (pc)
      STEP_SQ:     w = '{op: OP_SQ,     skip_jump: 1'b1, target: STEP_STEER,  last: 1'b0};
      STEP_SCALE:  w = '{op: OP_SCALE,  skip_jump: 1'b0, target: STEP_RECIP,  last: 1'b0};
      STEP_RECIP:  w = '{op: OP_RECIP,  skip_jump: 1'b0, target: STEP_STEER,  last: 1'b0};
      STEP_STEER:  w = '{op: OP_STEER,  skip_jump: 1'b0, target: STEP_COMMIT, last: 1'b0};
      STEP_COMMIT: w = '{op: OP_COMMIT, skip_jump: 1'b0, target: STEP_COMMIT, last: 1'b1};
      default:     w = '{op: OP_COMMIT, skip_jump: 1'b0, target: STEP_COMMIT, last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/lfsc_if.sv -----
// Valid/ready channel interfaces for control ticks and their results.
interface lfsc_tick_if;
  logic               valid;
  logic               ready;
  logic [7:0]         line_position;
  logic [7:0]         left_breaks;
  logic [7:0]         right_breaks;
  logic [7:0]         end_left_breaks;
  logic [7:0]         end_right_breaks;
  logic [7:0]         end_middle_breaks;
  logic signed [15:0] wheel_feedback;

  modport source (
    output valid, line_position, left_breaks, right_breaks,
    output end_left_breaks, end_right_breaks, end_middle_breaks, wheel_feedback,
    input  ready
  );
  modport sink (
    input  valid, line_position, left_breaks, right_breaks,
    input  end_left_breaks, end_right_breaks, end_middle_breaks, wheel_feedback,
    output ready
  );
endinterface

interface lfsc_result_if;
  logic        valid;
  logic        ready;
  logic [8:0]  motor_pwm;
  logic [15:0] servo_pwm;
  logic        race_started;
  logic        race_finished;
  logic        boosting;

  modport source (
    output valid, motor_pwm, servo_pwm, race_started, race_finished, boosting,
    input  ready
  );
  modport sink (
    input  valid, motor_pwm, servo_pwm, race_started, race_finished, boosting,
    output ready
  );
endinterface

// ----- sv/line_follow_speed_steer_control.sv -----
// Program: square, scale, divide, steer, commit; when the speed is overridden (both modes,
// boost or not started) it jumps from square to steer. A new tick is taken only at idle.
// The commit step waits while the result is held, and the five-step program runs
// through the single shared 22x22 multiplier.
// Reset: synchronous; registers return to their documented values, the controller state
// to its start-of-race values, and the result register empties.
module line_follow_speed_steer_control #(
  parameter int POSITION_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  lfsc_tick_if.sink            tick,
  lfsc_result_if.source        result
);

  localparam logic [7:0] POS_MASK =
    (POSITION_BITS >= 8) ? 8'hFF : 8'((1 << POSITION_BITS) - 1);

  // Configuration registers.
  logic        mode_fast, mode_sharp, adaptive_gain;
  logic [7:0]  line_center;
  logic [15:0] servo_center, servo_low, servo_high;

  // Controller state.
  logic signed [8:0] last_error;
  logic [4:0]        steer_gain;
  logic              boost_on;
  logic [7:0]        boost_ticks;
  logic              started;
  logic [8:0]        start_ticks;
  logic              finished;
  logic [5:0]        finish_ticks;
  logic [15:0]       held_servo;

  // Per-tick working registers.
  logic signed [8:0]  err_r;
  logic               end_ok_r;
  logic               fb_zero_r;
  logic signed [43:0] prod;
  logic [16:0]        q_r;

  // Result register.
  logic        out_valid;
  logic [8:0]  motor_r;
  logic [15:0] servo_r;
  logic        started_r, finished_r, boosting_r;

  lfsc_pkg::seq_ctl_t ctl;
  logic               tick_fire, skip, hold, commit;

  assign tick_fire = tick.valid && tick.ready;
  assign tick.ready = !ctl.run;
  assign skip = (mode_fast && mode_sharp) || boost_on || !started;
  assign hold = out_valid && !result.ready;
  assign commit = ctl.run && (ctl.uc.op == lfsc_pkg::OP_COMMIT) && !hold;

  lfsc_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (tick_fire),
    .skip  (skip),
    .hold  (hold),
    .ctl   (ctl)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_fast     <= 1'b0;
      mode_sharp    <= 1'b0;
      adaptive_gain <= 1'b0;
      line_center   <= 8'd64;
      servo_center  <= 16'd1500;
      servo_low     <= 16'd1200;
      servo_high    <= 16'd1800;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lfsc_pkg::REG_MODE_FAST:     mode_fast     <= cfg_data[0];
        lfsc_pkg::REG_MODE_SHARP:    mode_sharp    <= cfg_data[0];
        lfsc_pkg::REG_ADAPTIVE_GAIN: adaptive_gain <= cfg_data[0];
        lfsc_pkg::REG_LINE_CENTER:   line_center   <= cfg_data[7:0];
        lfsc_pkg::REG_SERVO_CENTER:  servo_center  <= cfg_data;
        lfsc_pkg::REG_SERVO_LOW:     servo_low     <= cfg_data;
        lfsc_pkg::REG_SERVO_HIGH:    servo_high    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line error of the incoming tick; a lost line repeats the last error.
  logic [7:0]        pos_m, ctr_m;
  logic signed [8:0] err_in;
  always_comb begin
    pos_m  = tick.line_position & POS_MASK;
    ctr_m  = line_center & POS_MASK;
    err_in = $signed({1'b0, pos_m}) - $signed({1'b0, ctr_m});
    if (tick.left_breaks > lfsc_pkg::LOST_LIMIT && tick.right_breaks > lfsc_pkg::LOST_LIMIT) begin
      err_in = last_error;
    end
  end

  // Capture the tick.
  always_ff @(posedge clk) begin
    if (tick_fire) begin
      err_r     <= err_in;
      end_ok_r  <= (tick.end_left_breaks > 8'd2) && (tick.end_right_breaks > 8'd2)
                   && (tick.end_middle_breaks > 8'd3);
      fb_zero_r <= (tick.wheel_feedback == 16'sd0);
    end
  end

  // Magnitude of the previous error and the profile it selects.
  logic signed [8:0] last_abs9;
  logic [7:0]        pe;
  logic [5:0]        factor;
  logic [8:0]        base, floor_v;
  always_comb begin
    last_abs9 = last_error[8] ? -last_error : last_error;
    pe        = last_abs9[7:0];
    if (mode_sharp) begin
      base    = lfsc_pkg::BASE_FAST;
      floor_v = lfsc_pkg::FLOOR_SHARP;
      factor  = (pe < 8'd3) ? lfsc_pkg::FACTOR_20 :
                (pe > 8'd13) ? lfsc_pkg::FACTOR_36 : lfsc_pkg::FACTOR_30;
    end else if (mode_fast) begin
      base    = lfsc_pkg::BASE_FAST;
      floor_v = lfsc_pkg::FLOOR_FAST;
      factor  = (pe < 8'd5) ? lfsc_pkg::FACTOR_20 :
                (pe > 8'd12) ? lfsc_pkg::FACTOR_8 : lfsc_pkg::FACTOR_17;
    end else begin
      base    = lfsc_pkg::BASE_DEFAULT;
      floor_v = lfsc_pkg::FLOOR_DEFAULT;
      factor  = (pe < 8'd3) ? lfsc_pkg::FACTOR_20 : lfsc_pkg::FACTOR_30;
    end
  end

  // Steering gain for this tick and the derivative-weighted error.
  logic signed [8:0]  err_abs9;
  logic [4:0]         gain_new;
  logic signed [10:0] steer_d;
  always_comb begin
    err_abs9 = err_r[8] ? -err_r : err_r;
    gain_new = steer_gain;
    if (adaptive_gain) begin
      gain_new = (err_abs9 > 9'sd4) ? lfsc_pkg::GAIN_HIGH : lfsc_pkg::GAIN_LOW;
    end
    steer_d = $signed({err_r[8], err_r, 1'b0}) - $signed({{2{last_error[8]}}, last_error});
  end

  // Shared multiplier operand selection.
  logic signed [21:0] mul_a, mul_b;
  logic [21:0]        rnd;
  always_comb begin
    rnd = prod[21:0] + 22'd19;
    unique case (ctl.uc.op)
      lfsc_pkg::OP_SQ: begin
        mul_a = $signed({14'd0, pe});
        mul_b = $signed({14'd0, pe});
      end
      lfsc_pkg::OP_SCALE: begin
        mul_a = $signed({5'd0, prod[16:0]});
        mul_b = $signed({16'd0, factor});
      end
      lfsc_pkg::OP_RECIP: begin
        mul_a = $signed({2'd0, rnd[21:2]});
        mul_b = $signed({1'b0, lfsc_pkg::RECIP_MUL});
      end
      lfsc_pkg::OP_STEER: begin
        mul_a = $signed({17'd0, gain_new});
        mul_b = $signed({{11{steer_d[10]}}, steer_d});
      end
      default: begin
        mul_a = 22'sd0;
        mul_b = 22'sd0;
      end
    endcase
  end

  // Product register; the quotient is kept before the steering product replaces it.
  always_ff @(posedge clk) begin
    if (ctl.run && ctl.uc.op != lfsc_pkg::OP_COMMIT) begin
      prod <= mul_a * mul_b;
    end
    if (ctl.run && ctl.uc.op == lfsc_pkg::OP_STEER) begin
      q_r <= prod[lfsc_pkg::RECIP_SHIFT+16:lfsc_pkg::RECIP_SHIFT];
    end
  end

  // Clamp to the servo range, low bound first.
  function automatic logic [15:0] servo_clamp(input logic signed [18:0] v,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
    logic [15:0] r;
    if (v <= $signed({3'd0, lo})) begin
      r = lo;
    end else if (v >= $signed({3'd0, hi})) begin
      r = hi;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Commit arithmetic: speed, timers, steering and the finish latch.
  logic signed [17:0] prof_diff;
  logic [8:0]         speed;
  logic [7:0]         boost_ticks_inc;
  logic               boost_after;
  logic [5:0]         finish_ticks_next;
  logic signed [18:0] turn, mirror;
  logic [15:0]        turn_c, mirror_c;
  logic [15:0]        held_next;
  logic               finished_next;
  logic [8:0]         start_ticks_next;
  logic               started_next;
  logic               boost_next;
  logic [7:0]         boost_ticks_next;
  always_comb begin
    prof_diff = $signed({9'd0, base}) - $signed({1'b0, q_r});
    if (prof_diff < $signed({9'd0, floor_v})) begin
      speed = floor_v;
    end else begin
      speed = prof_diff[8:0];
    end
    if (mode_fast && mode_sharp) begin
      speed = lfsc_pkg::SPEED_BOTH;
    end

    // Launch boost.
    boost_ticks_inc = (boost_ticks != 8'hFF) ? boost_ticks + 8'd1 : boost_ticks;
    boost_after      = boost_on;
    boost_ticks_next = boost_ticks;
    if (boost_on) begin
      speed            = lfsc_pkg::SPEED_BOOST;
      boost_ticks_next = boost_ticks_inc;
      if (pe > 8'd3 || boost_ticks_inc > lfsc_pkg::BOOST_LIMIT) begin
        boost_after = 1'b0;
      end
    end
    if (!started) begin
      speed = 9'd0;
    end

    // Finish stop.
    finish_ticks_next = finish_ticks;
    if (finished) begin
      if (finish_ticks < lfsc_pkg::FINISH_SAT) begin
        finish_ticks_next = finish_ticks + 6'd1;
      end
      if (finish_ticks_next > lfsc_pkg::FINISH_LIMIT) begin
        speed = 9'd0;
      end
    end

    // Steering around the center, then mirrored.
    turn     = $signed({3'd0, servo_center}) - $signed({{2{prod[16]}}, prod[16:0]});
    turn_c   = servo_clamp(turn, servo_low, servo_high);
    mirror   = $signed({2'd0, servo_center, 1'b0}) - $signed({3'd0, turn_c});
    mirror_c = servo_clamp(mirror, servo_low, servo_high);
    held_next = finished ? held_servo : mirror_c;

    finished_next = finished || (started && !boost_after && end_ok_r);

    // Start delay.
    start_ticks_next = start_ticks;
    started_next     = started;
    if (!started) begin
      start_ticks_next = start_ticks + 9'd1;
      if (start_ticks_next > lfsc_pkg::START_LIMIT) begin
        started_next = 1'b1;
      end
    end

    // A stopped wheel rearms the boost.
    boost_next = boost_after;
    if (fb_zero_r) begin
      boost_next       = 1'b1;
      boost_ticks_next = 8'd0;
    end
  end

  // State update on commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error   <= 9'sd0;
      steer_gain   <= lfsc_pkg::GAIN_RESET;
      boost_on     <= 1'b1;
      boost_ticks  <= 8'd0;
      started      <= 1'b0;
      start_ticks  <= 9'd0;
      finished     <= 1'b0;
      finish_ticks <= 6'd0;
      held_servo   <= 16'd1500;
    end else if (commit) begin
      last_error   <= err_r;
      steer_gain   <= gain_new;
      boost_on     <= boost_next;
      boost_ticks  <= boost_ticks_next;
      started      <= started_next;
      start_ticks  <= start_ticks_next;
      finished     <= finished_next;
      finish_ticks <= finish_ticks_next;
      held_servo   <= held_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      motor_r    <= lfsc_pkg::PWM_TOP - speed;
      servo_r    <= held_next;
      started_r  <= started_next;
      finished_r <= finished_next;
      boosting_r <= boost_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.motor_pwm     = motor_r;
  assign result.servo_pwm     = servo_r;
  assign result.race_started  = started_r;
  assign result.race_finished = finished_r;
  assign result.boosting      = boosting_r;

  // The finish latch never releases.
  a_finish_sticky: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("finish latch released");

  // Started only once the start delay has run out.
  a_start_delay: assert property (@(posedge clk) disable iff (rst)
    started |-> start_ticks > lfsc_pkg::START_LIMIT)
    else $error("started before the start delay elapsed");

  // A commit always lands in an empty or draining result register.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    commit |-> (!out_valid || result.ready))
    else $error("result overwritten");

  // Motor PWM stays within its range.
  a_motor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> motor_r <= lfsc_pkg::PWM_TOP)
    else $error("motor PWM out of range");

  // A tick transfer starts the program on the next cycle.
  a_tick_runs: assert property (@(posedge clk) disable iff (rst)
    tick_fire |=> ctl.run && ctl.uc.op == lfsc_pkg::OP_SQ)
    else $error("program did not start after a tick");

endmodule

// ----- sv/lfsc_seq.sv -----
// Microcode sequencer: step counter, program table and conditional jump.
module lfsc_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                skip,
  input  logic                hold,
  output lfsc_pkg::seq_ctl_t  ctl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } seq_state_t;

  seq_state_t                       state, state_next;
  logic [lfsc_pkg::PC_BITS-1:0]     pc, pc_next;
  lfsc_pkg::ucode_t                 uc;

  // Fetch the control word for the current step.
  always_comb begin
    uc = lfsc_pkg::ucode_rom(pc);
  end

  // Advance, jump or finish the program.
  always_comb begin
    state_next = state;
    pc_next    = pc;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_RUN;
          pc_next    = lfsc_pkg::STEP_SQ;
        end
      end
      S_RUN: begin
        if (uc.last) begin
          if (!hold) begin
            state_next = S_IDLE;
          end
        end else if (uc.skip_jump && skip) begin
          pc_next = uc.target;
        end else begin
          pc_next = pc + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= lfsc_pkg::STEP_SQ;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  assign ctl.run = (state == S_RUN);
  assign ctl.uc  = uc;

endmodule

// ----- verif/line_follow_speed_steer_control_tb.sv -----
// Self-checking testbench for the line-follow speed and steering controller.
module line_follow_speed_steer_control_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One control tick as it crosses the tick channel.
  typedef struct packed {
    logic [7:0]  line_position;
    logic [7:0]  left_breaks;
    logic [7:0]  right_breaks;
    logic [7:0]  end_left_breaks;
    logic [7:0]  end_right_breaks;
    logic [7:0]  end_middle_breaks;
    logic [15:0] wheel_feedback;
  } tick_t;

  // One set of control outputs as it crosses the result channel.
  typedef struct packed {
    logic [8:0]  motor_pwm;
    logic [15:0] servo_pwm;
    logic        race_started;
    logic        race_finished;
    logic        boosting;
  } controls_t;

  // A directed tick, with its outputs typed in where they are obvious.
  typedef struct packed {
    tick_t     stim;
    logic      typed;
    controls_t want;
  } directed_row_t;

  localparam int TICKS_PER_PHASE = 150;
  localparam int PHASES          = 12;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  lfsc_tick_if   tick_ch ();
  lfsc_result_if result_ch ();

  line_follow_speed_steer_control u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .result    (result_ch)
  );

  // Configuration copy kept by the predictor.
  logic        cfg_fast;
  logic        cfg_sharp;
  logic        cfg_adaptive;
  logic [7:0]  cfg_line_center;
  logic [15:0] cfg_servo_center;
  logic [15:0] cfg_servo_low;
  logic [15:0] cfg_servo_high;

  // Controller state kept by the predictor.
  int          prev_error;
  logic [4:0]  gain;
  logic        boost_active;
  logic [7:0]  boost_count;
  logic        race_on;
  logic [8:0]  start_count;
  logic        race_done;
  logic [5:0]  finish_count;
  logic [15:0] servo_hold;

  controls_t       pending_controls[$];
  directed_row_t   directed_rows[$];
  int              mismatches;
  int              ticks_taken;
  int              send_idle_pct;
  int              recv_idle_pct;
  logic            drv_typed;
  controls_t       drv_want;

  // Free-running clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Speed from a base, a floor and the slowdown factor in twentieths.
  function automatic int slowed_speed(input int base, input int floor_v, input int sq,
                                      input int factor);
    int s;
    s = base - (sq * factor + 19) / 20;
    return (s < floor_v) ? floor_v : s;
  endfunction

  // Low limit wins over the high limit, even when the two are crossed.
  function automatic int limit_servo(input int v);
    if (v <= int'(cfg_servo_low)) return int'(cfg_servo_low);
    if (v >= int'(cfg_servo_high)) return int'(cfg_servo_high);
    return v;
  endfunction

  // Advances the controller state by one tick and returns its outputs.
  task automatic compute_controls(input tick_t t, output controls_t r);
    int pe, sq, speed, err, last, turn, mirrored;
    pe = (prev_error < 0) ? -prev_error : prev_error;
    sq = pe * pe;

    // Speed comes from the error of the tick before.
    if (cfg_fast && cfg_sharp)
      speed = 170;
    else if (cfg_sharp)
      speed = slowed_speed(260, 210, sq, (pe < 3) ? 20 : ((pe > 13) ? 36 : 30));
    else if (cfg_fast)
      speed = slowed_speed(260, 190, sq, (pe < 5) ? 20 : ((pe > 12) ? 8 : 17));
    else
      speed = slowed_speed(185, 150, sq, (pe < 3) ? 20 : 30);

    if (boost_active) begin
      speed = 300;
      if (boost_count < 8'd255) boost_count = boost_count + 8'd1;
      if (pe > 3 || boost_count > 8'd120) boost_active = 1'b0;
    end
    if (!race_on) speed = 0;
    if (race_done) begin
      if (finish_count < 6'd41) finish_count = finish_count + 6'd1;
      if (finish_count > 6'd40) speed = 0;
    end

    // Steering: a PD step against the previous error, clamped and mirrored.
    last = prev_error;
    err = int'(t.line_position) - int'(cfg_line_center);
    if (t.left_breaks > 8'd50 && t.right_breaks > 8'd50) err = last;
    prev_error = err;
    if (cfg_adaptive) gain = (err > 4 || err < -4) ? 5'd30 : 5'd5;
    turn = int'(cfg_servo_center) - err * int'(gain) - (err - last) * int'(gain);
    turn = limit_servo(turn);
    mirrored = limit_servo(2 * int'(cfg_servo_center) - turn);
    if (!race_done) servo_hold = 16'(mirrored);

    // The finish mark latches only once racing without boost.
    if (race_on && !boost_active && t.end_left_breaks > 8'd2 &&
        t.end_right_breaks > 8'd2 && t.end_middle_breaks > 8'd3)
      race_done = 1'b1;

    if (!race_on) begin
      start_count = start_count + 9'd1;
      if (start_count > 9'd400) race_on = 1'b1;
    end

    // A stopped wheel rearms the launch boost.
    if (t.wheel_feedback == 16'd0) begin
      boost_active = 1'b1;
      boost_count = 8'd0;
    end

    r.motor_pwm     = 9'(500 - speed);
    r.servo_pwm     = servo_hold;
    r.race_started  = race_on;
    r.race_finished = race_done;
    r.boosting      = boost_active;
  endtask

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    mismatches++;
  endtask

  // Watch both channels and the configuration port at each rising edge.
  always @(posedge clk) begin : monitor
    tick_t     seen;
    controls_t predicted;
    controls_t want;
    controls_t got;
    if (!rst) begin
      if (cfg_write) begin
        case (lfsc_pkg::cfg_reg_t'(cfg_index))
          lfsc_pkg::REG_MODE_FAST:     cfg_fast = cfg_data[0];
          lfsc_pkg::REG_MODE_SHARP:    cfg_sharp = cfg_data[0];
          lfsc_pkg::REG_ADAPTIVE_GAIN: cfg_adaptive = cfg_data[0];
          lfsc_pkg::REG_LINE_CENTER:   cfg_line_center = cfg_data[7:0];
          lfsc_pkg::REG_SERVO_CENTER:  cfg_servo_center = cfg_data;
          lfsc_pkg::REG_SERVO_LOW:     cfg_servo_low = cfg_data;
          lfsc_pkg::REG_SERVO_HIGH:    cfg_servo_high = cfg_data;
          default: ;
        endcase
      end

      // Tick transfer: predict, then queue the expected outputs.
      if (tick_ch.valid && tick_ch.ready) begin
        seen = '{tick_ch.line_position, tick_ch.left_breaks, tick_ch.right_breaks,
                 tick_ch.end_left_breaks, tick_ch.end_right_breaks,
                 tick_ch.end_middle_breaks, tick_ch.wheel_feedback};
        compute_controls(seen, predicted);
        pending_controls.push_back(drv_typed ? drv_want : predicted);
        ticks_taken++;
      end

      // Result transfer: compare against the oldest expectation.
      if (result_ch.valid && result_ch.ready) begin
        got = '{result_ch.motor_pwm, result_ch.servo_pwm, result_ch.race_started,
                result_ch.race_finished, result_ch.boosting};
        if (pending_controls.size() == 0) begin
          $display("%0t: result with nothing expected, got motor %0d servo %0d",
                   $time, got.motor_pwm, got.servo_pwm);
          mismatches++;
        end else begin
          want = pending_controls.pop_front();
          if (got.motor_pwm !== want.motor_pwm)
            report_field("motor_pwm", 16'(want.motor_pwm), 16'(got.motor_pwm));
          if (got.servo_pwm !== want.servo_pwm)
            report_field("servo_pwm", want.servo_pwm, got.servo_pwm);
          if (got.race_started !== want.race_started)
            report_field("race_started", 16'(want.race_started), 16'(got.race_started));
          if (got.race_finished !== want.race_finished)
            report_field("race_finished", 16'(want.race_finished),
                         16'(got.race_finished));
          if (got.boosting !== want.boosting)
            report_field("boosting", 16'(want.boosting), 16'(got.boosting));
        end
      end
    end
  end

  // Receiver side: random stalls at the current rate.
  always @(negedge clk) begin
    if (rst)
      result_ch.ready = 1'b0;
    else
      result_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic add_row(input int pos, input int lb, input int rb, input int el,
                         input int er, input int em, input int wf, input bit typed,
                         input int motor, input int servo, input bit st, input bit fin,
                         input bit bst);
    directed_row_t row;
    row.stim  = '{8'(pos), 8'(lb), 8'(rb), 8'(el), 8'(er), 8'(em), 16'(wf)};
    row.typed = typed;
    row.want  = '{9'(motor), 16'(servo), st, fin, bst};
    directed_rows.push_back(row);
  endtask

  // Drives one tick and returns at the falling edge after its transfer.
  task automatic send_tick(input tick_t t, input logic typed, input controls_t want);
    int taken;
    while ($urandom_range(99) < send_idle_pct) begin
      tick_ch.valid = 1'b0;
      @(negedge clk);
    end
    tick_ch.valid             = 1'b1;
    tick_ch.line_position     = t.line_position;
    tick_ch.left_breaks       = t.left_breaks;
    tick_ch.right_breaks      = t.right_breaks;
    tick_ch.end_left_breaks   = t.end_left_breaks;
    tick_ch.end_right_breaks  = t.end_right_breaks;
    tick_ch.end_middle_breaks = t.end_middle_breaks;
    tick_ch.wheel_feedback    = t.wheel_feedback;
    drv_typed = typed;
    drv_want  = want;
    taken = ticks_taken;
    do @(negedge clk); while (ticks_taken == taken);
  endtask

  // Random tick: the line mostly near center, the finish mark held off unless allowed.
  function automatic tick_t random_tick(input bit finish_ok);
    tick_t t;
    int    d;
    case ($urandom_range(9))
      0, 1, 2, 3: d = int'($urandom_range(6)) - 3;
      4, 5, 6, 7: d = int'($urandom_range(40)) - 20;
      default:    d = int'($urandom_range(255));
    endcase
    t.line_position = cfg_line_center + 8'(d);
    if ($urandom_range(9) == 0) begin
      t.left_breaks  = 8'(51 + $urandom_range(204));
      t.right_breaks = 8'(51 + $urandom_range(204));
    end else begin
      t.left_breaks  = 8'($urandom);
      t.right_breaks = 8'($urandom);
    end
    t.end_left_breaks   = 8'($urandom);
    t.end_right_breaks  = 8'($urandom);
    t.end_middle_breaks = 8'($urandom);
    if (!finish_ok || $urandom_range(99) >= 15) begin
      case ($urandom_range(2))
        0:       t.end_left_breaks = 8'($urandom_range(2));
        1:       t.end_right_breaks = 8'($urandom_range(2));
        default: t.end_middle_breaks = 8'($urandom_range(3));
      endcase
    end
    t.wheel_feedback = ($urandom_range(24) == 0) ? 16'd0 : 16'($urandom);
    return t;
  endfunction

  task automatic write_cfg(input lfsc_pkg::cfg_reg_t idx, input logic [15:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
  endtask

  // Per-phase settings: extremes and crossed limits first, then every speed mode.
  task automatic configure_phase(input int p);
    logic        fast, sharp, adapt;
    logic [7:0]  lc;
    logic [15:0] sc, lo, hi;
    case (p)
      0: begin
        fast = 1'b0; sharp = 1'b0; adapt = 1'b1; lc = 8'd0;
        sc = 16'd0; lo = 16'd0; hi = 16'd65535;
      end
      1: begin
        fast = 1'b0; sharp = 1'b0; adapt = 1'b0; lc = 8'd255;
        sc = 16'd65535; lo = 16'd65535; hi = 16'd0;
      end
      2: begin
        fast = 1'b0; sharp = 1'b0; adapt = 1'b1; lc = 8'd64;
        sc = 16'd1500; lo = 16'd1800; hi = 16'd1200;
      end
      default: begin
        fast  = p[0];
        sharp = p[1];
        adapt = 1'($urandom_range(1));
        lc    = $urandom_range(1) ? 8'd64 : 8'($urandom);
        sc    = 16'(1000 + $urandom_range(1000));
        lo    = sc - 16'($urandom_range(500));
        hi    = sc + 16'($urandom_range(500));
        if ($urandom_range(3) == 0) begin
          sc = 16'($urandom);
          lo = 16'($urandom);
          hi = 16'($urandom);
        end
      end
    endcase
    write_cfg(lfsc_pkg::REG_MODE_FAST, {15'd0, fast});
    write_cfg(lfsc_pkg::REG_MODE_SHARP, {15'd0, sharp});
    write_cfg(lfsc_pkg::REG_ADAPTIVE_GAIN, {15'd0, adapt});
    write_cfg(lfsc_pkg::REG_LINE_CENTER, {8'd0, lc});
    write_cfg(lfsc_pkg::REG_SERVO_CENTER, sc);
    write_cfg(lfsc_pkg::REG_SERVO_LOW, lo);
    write_cfg(lfsc_pkg::REG_SERVO_HIGH, hi);
    cfg_write = 1'b0;
  endtask

  // Main sequence: reset, directed ticks, then random phases under changing settings.
  initial begin : stimulus
    controls_t none;
    none = '0;

    rst                       = 1'b1;
    cfg_write                 = 1'b0;
    cfg_index                 = '0;
    cfg_data                  = '0;
    tick_ch.valid             = 1'b0;
    tick_ch.line_position     = '0;
    tick_ch.left_breaks       = '0;
    tick_ch.right_breaks      = '0;
    tick_ch.end_left_breaks   = '0;
    tick_ch.end_right_breaks  = '0;
    tick_ch.end_middle_breaks = '0;
    tick_ch.wheel_feedback    = '0;
    result_ch.ready           = 1'b0;
    drv_typed                 = 1'b0;
    drv_want                  = '0;
    mismatches                = 0;
    ticks_taken               = 0;
    send_idle_pct             = 38;
    recv_idle_pct             = 80;

    // Reset values of the predictor.
    cfg_fast = 1'b0; cfg_sharp = 1'b0; cfg_adaptive = 1'b0; cfg_line_center = 8'd64;
    cfg_servo_center = 16'd1500; cfg_servo_low = 16'd1200; cfg_servo_high = 16'd1800;
    prev_error = 0; gain = 5'd25; boost_active = 1'b1; boost_count = 8'd0;
    race_on = 1'b0; start_count = 9'd0; race_done = 1'b0; finish_count = 6'd0;
    servo_hold = 16'd1500;

    // Straight ahead, full right and full left swings, line lost, break threshold.
    add_row(64, 0, 0, 0, 0, 0, 1, 1, 500, 1500, 0, 0, 1);
    add_row(255, 0, 0, 0, 0, 0, 'h8000, 1, 500, 1800, 0, 0, 1);
    add_row(0, 0, 0, 0, 0, 0, 'h7fff, 1, 500, 1200, 0, 0, 0);
    add_row(0, 51, 51, 0, 0, 0, 0, 1, 500, 1200, 0, 0, 1);
    add_row(64, 50, 255, 0, 0, 0, 1, 1, 500, 1800, 0, 0, 0);
    // Finish marks before the start, field extremes and small errors.
    add_row(255, 255, 50, 255, 255, 255, 'h5555, 0, 0, 0, 0, 0, 0);
    add_row(1, 51, 255, 3, 3, 4, 'hffff, 0, 0, 0, 0, 0, 0);
    add_row(128, 255, 255, 2, 2, 3, 'h00ff, 0, 0, 0, 0, 0, 0);
    add_row(127, 0, 51, 128, 127, 64, 0, 0, 0, 0, 0, 0, 0);
    add_row(64, 10, 10, 0, 0, 0, 'h0001, 0, 0, 0, 0, 0, 0);
    add_row(66, 0, 0, 0, 0, 0, 'h0100, 0, 0, 0, 0, 0, 0);
    add_row(61, 0, 0, 0, 0, 0, 'h7fff, 0, 0, 0, 0, 0, 0);
    add_row(68, 0, 0, 0, 0, 0, 'h8001, 0, 0, 0, 0, 0, 0);
    add_row(64, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(254, 170, 85, 170, 85, 170, 'haaaa, 0, 0, 0, 0, 0, 0);
    add_row(64, 85, 170, 85, 170, 85, 'h5555, 0, 0, 0, 0, 0, 0);
    add_row(63, 51, 51, 0, 0, 0, 'h0002, 0, 0, 0, 0, 0, 0);
    add_row(65, 200, 200, 255, 255, 255, 0, 0, 0, 0, 0, 0, 0);
    add_row(64, 0, 0, 255, 255, 255, 'h1234, 0, 0, 0, 0, 0, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_tick(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 4) begin
        send_idle_pct = 80;
        recv_idle_pct = 38;
      end else if (p == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Settings change only once every expected result has arrived.
      tick_ch.valid = 1'b0;
      while (pending_controls.size() != 0) @(negedge clk);
      configure_phase(p);
      // The finish mark is let through only after the first 20 ticks of the last phase.
      for (int n = 0; n < TICKS_PER_PHASE; n++)
        send_tick(random_tick(p == PHASES - 1 && n >= 20), 1'b0, none);
    end

    tick_ch.valid = 1'b0;
    while (pending_controls.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
